>>> src/dft_pkg.sv
// Shared types and constants for the delimited field tokenizer.
// Used by dft_core, dft_out_buf and delimited_field_tokenizer; depends on nothing.
package dft_pkg;

    localparam int unsigned WIDTH_LIMIT_DEFAULT = 255;
    localparam logic [7:0]  SPACE_CHAR          = 8'd32;
    localparam logic [7:0]  DEFAULT_DELIM       = 8'd44;
    localparam logic [7:0]  BYTE_MAX            = 8'hFF;

    typedef struct packed {
        logic       char_valid;
        logic [7:0] out_char;
        logic [7:0] spaces_before;
        logic       field_end;
        logic       more_follows;
        logic [7:0] field_length;
        logic [7:0] widest_seen;
        logic       empty_field_error;
    } result_t;

endpackage

>>> src/delimited_field_tokenizer.sv
// Top level of the delimited field tokenizer.
// Depends on dft_pkg, dft_core and dft_out_buf.
//
// Usage:
//   Input channel (in_valid/in_stall) carries one byte of a line per transfer,
//   with line_end set on the last byte. Output channel (out_valid/out_stall)
//   carries at most one result per input byte: a trimmed character with its
//   held interior space count, a field close with length and widest length,
//   or an empty-field error. Bytes that give no result produce no transfer.
//   Configuration channel (cfg_valid/cfg_ready/cfg_data) sets the delimiter;
//   cfg_ready is always high. Write it only while the block is idle.
//   A result is registered in the output register, or in the skid register
//   while the output register is held. Throughput: one byte per cycle while
//   in_stall is low; step logic ahead of the output register is combinational.
//   Stall: results collect in a two-entry buffer; in_stall rises when the
//   second entry is occupied and falls once the output register drains.
//   Reset: state returns to the start of a field, the widest length to zero,
//   the delimiter to comma, and both buffer entries empty.
module delimited_field_tokenizer #(
    parameter int unsigned WIDTH_LIMIT = dft_pkg::WIDTH_LIMIT_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       line_end,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       char_valid,
    output logic [7:0] out_char,
    output logic [7:0] spaces_before,
    output logic       field_end,
    output logic       more_follows,
    output logic [7:0] field_length,
    output logic [7:0] widest_seen,
    output logic       empty_field_error
);

    logic             accept;
    logic             produce;
    logic             full;
    dft_pkg::result_t step_result;
    dft_pkg::result_t head;

    assign cfg_ready = 1'b1;
    assign in_stall  = full;
    assign accept    = in_valid && !full;

    dft_core #(
        .WIDTH_LIMIT (WIDTH_LIMIT)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .in_byte   (in_byte),
        .line_end  (line_end),
        .produce   (produce),
        .result    (step_result)
    );

    dft_out_buf u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (accept && produce),
        .push_data  (step_result),
        .full       (full),
        .pop_stall  (out_stall),
        .head_valid (out_valid),
        .head_data  (head)
    );

    assign char_valid        = head.char_valid;
    assign out_char          = head.out_char;
    assign spaces_before     = head.spaces_before;
    assign field_end         = head.field_end;
    assign more_follows      = head.more_follows;
    assign field_length      = head.field_length;
    assign widest_seen       = head.widest_seen;
    assign empty_field_error = head.empty_field_error;

endmodule

>>> src/dft_core.sv
// Field state, delimiter register and combinational step logic of the tokenizer.
// Depends on dft_pkg for result_t and character constants.
module dft_core #(
    parameter int unsigned WIDTH_LIMIT = dft_pkg::WIDTH_LIMIT_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_write,
    input  logic [7:0]      cfg_data,
    input  logic            accept,
    input  logic [7:0]      in_byte,
    input  logic            line_end,
    output logic            produce,
    output dft_pkg::result_t result
);

    localparam int unsigned LW = $clog2(WIDTH_LIMIT + 1);
    localparam int unsigned SW = ((LW > 8) ? LW : 8) + 2;

    logic [7:0]    delim_reg;
    logic          at_start_reg, at_start_next;
    logic          seen_reg, seen_next;
    logic [7:0]    held_reg, held_next;
    logic [LW-1:0] run_reg, run_next;
    logic [LW-1:0] wid_reg, wid_next;
    logic          skip_reg, skip_next;

    logic          is_delim;
    logic          is_space;
    logic [SW-1:0] sum;
    logic [LW-1:0] run_sat;
    logic [LW-1:0] wid_max;
    logic [LW-1:0] wid_max_char;

    function automatic logic [7:0] cap8(input logic [LW-1:0] v);
        logic [SW-1:0] ve;
        ve = SW'(v);
        return (ve > SW'(255)) ? dft_pkg::BYTE_MAX : ve[7:0];
    endfunction

    assign is_delim     = (in_byte == delim_reg);
    assign is_space     = (in_byte == dft_pkg::SPACE_CHAR);
    assign sum          = SW'(run_reg) + SW'(held_reg) + SW'(1);
    assign run_sat      = (sum > SW'(WIDTH_LIMIT)) ? LW'(WIDTH_LIMIT) : sum[LW-1:0];
    assign wid_max      = (run_reg > wid_reg) ? run_reg : wid_reg;
    assign wid_max_char = (run_sat > wid_reg) ? run_sat : wid_reg;

    always_comb
    begin
        produce       = 1'b0;
        result        = '0;
        at_start_next = at_start_reg;
        seen_next     = seen_reg;
        held_next     = held_reg;
        run_next      = run_reg;
        wid_next      = wid_reg;
        skip_next     = skip_reg;
        priority if (skip_reg)
        begin
            if (line_end)
            begin
                skip_next     = 1'b0;
                at_start_next = 1'b1;
                seen_next     = 1'b0;
                held_next     = '0;
                run_next      = '0;
            end
        end
        else if (is_delim)
        begin
            produce = 1'b1;
            if (at_start_reg)
            begin
                result.empty_field_error = 1'b1;
                result.widest_seen       = cap8(wid_reg);
                if (line_end)
                begin
                    at_start_next = 1'b1;
                    seen_next     = 1'b0;
                    held_next     = '0;
                    run_next      = '0;
                end
                else
                begin
                    skip_next = 1'b1;
                end
            end
            else
            begin
                wid_next            = wid_max;
                result.field_end    = 1'b1;
                result.more_follows = !line_end;
                result.field_length = cap8(run_reg);
                result.widest_seen  = cap8(wid_max);
                at_start_next       = 1'b1;
                seen_next           = 1'b0;
                held_next           = '0;
                run_next            = '0;
            end
        end
        else
        begin
            at_start_next = 1'b0;
            if (is_space)
            begin
                if (seen_reg && (held_reg != dft_pkg::BYTE_MAX))
                begin
                    held_next = held_reg + 8'd1;
                end
                if (line_end)
                begin
                    wid_next            = wid_max;
                    produce             = 1'b1;
                    result.field_end    = 1'b1;
                    result.field_length = cap8(run_reg);
                    result.widest_seen  = cap8(wid_max);
                end
            end
            else
            begin
                produce              = 1'b1;
                result.char_valid    = 1'b1;
                result.out_char      = in_byte;
                result.spaces_before = held_reg;
                run_next             = run_sat;
                held_next            = '0;
                seen_next            = 1'b1;
                if (line_end)
                begin
                    wid_next            = wid_max_char;
                    result.field_end    = 1'b1;
                    result.field_length = cap8(run_sat);
                    result.widest_seen  = cap8(wid_max_char);
                end
                else
                begin
                    result.widest_seen = cap8(wid_reg);
                end
            end
            if (line_end)
            begin
                at_start_next = 1'b1;
                seen_next     = 1'b0;
                held_next     = '0;
                run_next      = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delim_reg    <= dft_pkg::DEFAULT_DELIM;
            at_start_reg <= 1'b1;
            seen_reg     <= 1'b0;
            held_reg     <= '0;
            run_reg      <= '0;
            wid_reg      <= '0;
            skip_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                delim_reg <= cfg_data;
            end
            if (accept)
            begin
                at_start_reg <= at_start_next;
                seen_reg     <= seen_next;
                held_reg     <= held_next;
                run_reg      <= run_next;
                wid_reg      <= wid_next;
                skip_reg     <= skip_next;
            end
        end
    end

`ifndef SYNTHESIS
    a_err_alone: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && produce && result.empty_field_error)
            |-> (!result.char_valid && !result.field_end))
        else $error("empty-field error combined with other result");
    a_len_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && produce && !result.field_end)
            |-> (result.field_length == 8'd0 && !result.more_follows))
        else $error("field length or more_follows outside a field end");
    a_widest_covers_len: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && produce && result.field_end)
            |-> (result.widest_seen >= result.field_length))
        else $error("widest field below closed field length");
`endif

endmodule

>>> src/dft_out_buf.sv
// Two-entry result buffer: output register plus skid register.
// Depends on dft_pkg for result_t.
module dft_out_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  dft_pkg::result_t  push_data,
    output logic              full,
    input  logic              pop_stall,
    output logic              head_valid,
    output dft_pkg::result_t  head_data
);

    logic             out_valid_reg, out_valid_next;
    logic             skid_valid_reg, skid_valid_next;
    dft_pkg::result_t out_data_reg, out_data_next;
    dft_pkg::result_t skid_data_reg, skid_data_next;
    logic             pop;

    assign pop        = out_valid_reg && !pop_stall;
    assign full       = skid_valid_reg;
    assign head_valid = out_valid_reg;
    assign head_data  = out_data_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = push;
                out_data_next  = push_data;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

`ifndef SYNTHESIS
    a_skid_behind_head: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held with empty output register");
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && skid_valid_reg))
        else $error("transfer into full buffer");
    a_push_to_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !out_valid_reg) |=> out_valid_reg)
        else $error("transfer into empty buffer not presented");
`endif

endmodule
